/* rtl/core/msd_pkg.sv */
package msd_pkg;

	localparam int SAMPLE_W         = 16;
	localparam int STD_W            = 15;
	localparam int SQ_W             = 2 * SAMPLE_W - 1;
	localparam int ROOT_W           = SAMPLE_W;
	localparam int RAD_W            = 2 * ROOT_W;
	localparam int MAX_SET_SIZE_DEF = 1048576;

	typedef struct packed {
		logic take;
		logic close;
		logic div_load_mean;
		logic div_step;
		logic mean_cap;
		logic div_load_sq;
		logic mul;
		logic var_load;
		logic sqrt_step;
		logic out_load;
	} msd_cmd_t;

	typedef struct packed {
		logic count_full;
		logic out_free;
	} msd_stat_t;

endpackage

/* rtl/core/msd_ctrl.sv */
module msd_ctrl #(
	parameter int MAX_SET_SIZE = msd_pkg::MAX_SET_SIZE_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_last,
	output logic              in_ready,
	input  msd_pkg::msd_stat_t stat,
	output msd_pkg::msd_cmd_t  cmd
);
	import msd_pkg::*;

	localparam int CNT_W  = $clog2(MAX_SET_SIZE + 1);
	localparam int SQS_W  = 2 * SAMPLE_W - 2 + CNT_W;
	localparam int STEP_W = $clog2(SQS_W);

	typedef enum logic [3:0] {
		ST_ACC,
		ST_FLUSH,
		ST_LOAD,
		ST_DIV_MEAN,
		ST_MEAN_CAP,
		ST_DIV_SQ,
		ST_MUL,
		ST_VAR,
		ST_SQRT,
		ST_DONE
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] step_q;
	logic              beat;

	assign in_ready = (state_q == ST_ACC);
	assign beat     = in_valid && in_ready;

	always_comb begin
		cmd               = '0;
		cmd.take          = beat;
		cmd.close         = in_last || stat.count_full;
		cmd.div_load_mean = (state_q == ST_LOAD);
		cmd.div_step      = (state_q == ST_DIV_MEAN) || (state_q == ST_DIV_SQ);
		cmd.mean_cap      = (state_q == ST_MEAN_CAP);
		cmd.div_load_sq   = (state_q == ST_MEAN_CAP);
		cmd.mul           = (state_q == ST_MUL);
		cmd.var_load      = (state_q == ST_VAR);
		cmd.sqrt_step     = (state_q == ST_SQRT);
		cmd.out_load      = (state_q == ST_DONE) && stat.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_ACC: begin
					if (beat && (in_last || stat.count_full)) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					state_q <= ST_DIV_MEAN;
					step_q  <= STEP_W'(SQS_W - 1);
				end
				ST_DIV_MEAN: begin
					if (step_q == '0) begin
						state_q <= ST_MEAN_CAP;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				ST_MEAN_CAP: begin
					state_q <= ST_DIV_SQ;
					step_q  <= STEP_W'(SQS_W - 1);
				end
				ST_DIV_SQ: begin
					if (step_q == '0) begin
						state_q <= ST_MUL;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				ST_MUL: begin
					state_q <= ST_VAR;
				end
				ST_VAR: begin
					state_q <= ST_SQRT;
					step_q  <= STEP_W'(ROOT_W - 1);
				end
				ST_SQRT: begin
					if (step_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				ST_DONE: begin
					if (stat.out_free) begin
						state_q <= ST_ACC;
					end
				end
				default: begin
					state_q <= ST_ACC;
				end
			endcase
		end
	end

endmodule

/* rtl/core/msd_dp.sv */
module msd_dp #(
	parameter int MAX_SET_SIZE = msd_pkg::MAX_SET_SIZE_DEF
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  msd_pkg::msd_cmd_t                              cmd,
	output msd_pkg::msd_stat_t                             stat,
	input  logic signed [msd_pkg::SAMPLE_W-1:0]            sample,
	input  logic                                           out_ready,
	output logic                                           out_valid,
	output logic signed [msd_pkg::SAMPLE_W-1:0]            out_mean,
	output logic [msd_pkg::STD_W-1:0]                      out_std_dev,
	output logic [$clog2(MAX_SET_SIZE + 1)-1:0]            out_count
);
	import msd_pkg::*;

	localparam int CNT_W = $clog2(MAX_SET_SIZE + 1);
	localparam int SUM_W = SAMPLE_W + CNT_W;
	localparam int SQS_W = 2 * SAMPLE_W - 2 + CNT_W;
	localparam int REM_W = ROOT_W + 2;

	logic [CNT_W-1:0]           count_q;
	logic                       valid_s1;
	logic                       close_s1;
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic [SQ_W-1:0]            square_s1;
	logic signed [2*SAMPLE_W-1:0] square_full;

	logic signed [SUM_W-1:0]    sum_q;
	logic [SQS_W-1:0]           sqsum_q;
	logic signed [SUM_W-1:0]    sum_nx;
	logic [SQS_W-1:0]           sqsum_nx;
	logic signed [SUM_W-1:0]    fin_sum_q;
	logic [SQS_W-1:0]           fin_sqsum_q;
	logic [CNT_W-1:0]           fin_cnt_q;

	logic [CNT_W-1:0]           rem_q;
	logic [SQS_W-1:0]           dvd_q;
	logic [CNT_W:0]             div_sh;
	logic                       div_ge;
	logic [CNT_W:0]             div_diff;
	logic [SUM_W-1:0]           sum_mag;
	logic                       mean_neg_q;
	logic signed [SAMPLE_W-1:0] mean_q;
	logic [SAMPLE_W-1:0]        mean_mag;

	logic [SQ_W-1:0]            mean_sq_q;
	logic [SQ_W-1:0]            sq_mean_q;
	logic signed [2*SAMPLE_W-1:0] mean_prod;

	logic [RAD_W-1:0]           rad_q;
	logic [REM_W-1:0]           srem_q;
	logic [ROOT_W-1:0]          root_q;
	logic [REM_W+1:0]           sq_sh;
	logic [REM_W+1:0]           sq_trial;
	logic                       sq_ge;
	logic [REM_W+1:0]           sq_diff;

	logic                       out_valid_q;

	assign stat.count_full = (count_q == CNT_W'(MAX_SET_SIZE - 1));
	assign stat.out_free   = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;

	assign square_full = sample * sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			valid_s1 <= 1'b0;
			close_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.take;
			close_s1 <= cmd.take && cmd.close;
			if (cmd.take) begin
				if (cmd.close) begin
					count_q <= '0;
				end else begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			sample_s1 <= sample;
			square_s1 <= square_full[SQ_W-1:0];
			if (cmd.close) begin
				fin_cnt_q <= count_q + 1'b1;
			end
		end
	end

	assign sum_nx   = sum_q + SUM_W'(sample_s1);
	assign sqsum_nx = sqsum_q + SQS_W'(square_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			sqsum_q <= '0;
		end else if (valid_s1) begin
			if (close_s1) begin
				sum_q   <= '0;
				sqsum_q <= '0;
			end else begin
				sum_q   <= sum_nx;
				sqsum_q <= sqsum_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && close_s1) begin
			fin_sum_q   <= sum_nx;
			fin_sqsum_q <= sqsum_nx;
		end
	end

	assign sum_mag  = fin_sum_q[SUM_W-1] ? SUM_W'(-fin_sum_q) : SUM_W'(fin_sum_q);
	assign div_sh   = {rem_q, dvd_q[SQS_W-1]};
	assign div_ge   = (div_sh >= {1'b0, fin_cnt_q});
	assign div_diff = div_sh - {1'b0, fin_cnt_q};
	assign mean_mag = dvd_q[SAMPLE_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.div_load_mean) begin
			rem_q      <= '0;
			dvd_q      <= SQS_W'(sum_mag);
			mean_neg_q <= fin_sum_q[SUM_W-1];
		end else if (cmd.div_load_sq) begin
			rem_q <= '0;
			dvd_q <= fin_sqsum_q;
		end else if (cmd.div_step) begin
			rem_q <= div_ge ? div_diff[CNT_W-1:0] : div_sh[CNT_W-1:0];
			dvd_q <= {dvd_q[SQS_W-2:0], div_ge};
		end
		if (cmd.mean_cap) begin
			mean_q <= mean_neg_q ? SAMPLE_W'(-mean_mag) : mean_mag;
		end
	end

	assign mean_prod = mean_q * mean_q;

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			mean_sq_q <= dvd_q[SQ_W-1:0];
			sq_mean_q <= mean_prod[SQ_W-1:0];
		end
	end

	assign sq_sh    = {srem_q, rad_q[RAD_W-1 -: 2]};
	assign sq_trial = {2'b00, root_q, 2'b01};
	assign sq_ge    = (sq_sh >= sq_trial);
	assign sq_diff  = sq_sh - sq_trial;

	always_ff @(posedge clk) begin
		if (cmd.var_load) begin
			rad_q  <= (mean_sq_q > sq_mean_q) ? RAD_W'(mean_sq_q - sq_mean_q) : '0;
			srem_q <= '0;
			root_q <= '0;
		end else if (cmd.sqrt_step) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			srem_q <= sq_ge ? sq_diff[REM_W-1:0] : sq_sh[REM_W-1:0];
			root_q <= {root_q[ROOT_W-2:0], sq_ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_mean    <= mean_q;
			out_std_dev <= root_q[ROOT_W-1] ? '1 : root_q[STD_W-1:0];
			out_count   <= fin_cnt_q;
		end
	end

endmodule

/* rtl/core/stream_mean_and_std_dev.sv */
// Samples are taken one per cycle while a set is being gathered.
// The beat that closes a set stalls the input while a shared one-bit-a-cycle divider
// and a two-bits-a-cycle root unit run.
// The result waits in an output register, so the next set is gathered while it is held.
// Reset clears the accumulators, the count and the output valid flag.
module stream_mean_and_std_dev #(
	parameter int MAX_SET_SIZE = msd_pkg::MAX_SET_SIZE_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [15:0]                            s_tdata, // sample
	input  logic                                   s_tlast, // last
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// mean, std_dev, sample_count, zero padding
	output logic [((2 * msd_pkg::SAMPLE_W - 1 + $clog2(MAX_SET_SIZE + 1) + 7) / 8) * 8 - 1:0]
	                                               m_tdata
);
	import msd_pkg::*;

	localparam int CNT_W = $clog2(MAX_SET_SIZE + 1);
	localparam int OUT_W = SAMPLE_W + STD_W + CNT_W;
	localparam int M_W   = ((OUT_W + 7) / 8) * 8;

	msd_cmd_t                   cmd;
	msd_stat_t                  stat;
	logic signed [SAMPLE_W-1:0] out_mean;
	logic [STD_W-1:0]           out_std_dev;
	logic [CNT_W-1:0]           out_count;

	msd_ctrl #(
		.MAX_SET_SIZE(MAX_SET_SIZE)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_last (s_tlast),
		.in_ready(s_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	msd_dp #(
		.MAX_SET_SIZE(MAX_SET_SIZE)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.sample     (s_tdata),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_mean   (out_mean),
		.out_std_dev(out_std_dev),
		.out_count  (out_count)
	);

	assign m_tdata = M_W'({out_count, out_std_dev, out_mean});

endmodule

/* tb/stream_mean_and_std_dev_tb.sv */
`timescale 1ns / 1ps

module stream_mean_and_std_dev_tb;

	localparam int MAX_SET  = msd_pkg::MAX_SET_SIZE_DEF;
	localparam int CNT_W    = $clog2(MAX_SET + 1);
	localparam int RES_W    = 2 * msd_pkg::SAMPLE_W - 1 + CNT_W;
	localparam int DATA_W   = ((RES_W + 7) / 8) * 8;
	localparam int LATENCY  = 2 * (30 + CNT_W) + 22;
	localparam int QUIET_MAX = 20000;
	localparam int HOLD_LEN = 800;
	localparam int PHASE_ITEMS = 375;

	class stats_scoreboard;
		typedef struct {
			logic signed [15:0] mean;
			logic [14:0]        std_dev;
			logic [CNT_W-1:0]   sample_count;
		} set_stats_t;

		longint     sum;
		longint     square_sum;
		longint     count;
		set_stats_t expected_stats[$];
		int         mismatches;

		function longint floor_root(longint radicand);
			longint root;
			longint probe;
			root = 0;
			probe = 64'sh4000_0000_0000_0000;
			while (probe > radicand)
				probe >>= 2;
			while (probe != 0) begin
				if (radicand >= root + probe) begin
					radicand -= root + probe;
					root = (root >> 1) + probe;
				end else begin
					root >>= 1;
				end
				probe >>= 2;
			end
			return root;
		endfunction

		function void note_sample(logic [15:0] smp, logic lst);
			longint     s;
			longint     avg;
			longint     mean_of_sq;
			longint     sq_of_mean;
			longint     spread;
			longint     dev;
			set_stats_t st;
			s = longint'($signed(smp));
			sum += s;
			square_sum += s * s;
			count++;
			if (!lst && count < MAX_SET)
				return;
			avg = sum / count;
			mean_of_sq = square_sum / count;
			sq_of_mean = avg * avg;
			spread = (mean_of_sq > sq_of_mean) ? mean_of_sq - sq_of_mean : 0;
			dev = floor_root(spread);
			if (dev > 32767)
				dev = 32767;
			st.mean = avg[15:0];
			st.std_dev = dev[14:0];
			st.sample_count = count[CNT_W-1:0];
			expected_stats.push_back(st);
			sum = 0;
			square_sum = 0;
			count = 0;
		endfunction

		function void check_result(logic [DATA_W-1:0] beat);
			set_stats_t st;
			if (expected_stats.size() == 0) begin
				$error("result beat %h arrived with no set pending", beat);
				mismatches++;
				return;
			end
			st = expected_stats.pop_front();
			if (beat[15:0] !== st.mean) begin
				$error("mean: expected %0d, actual %0d", st.mean, $signed(beat[15:0]));
				mismatches++;
			end
			if (beat[30:16] !== st.std_dev) begin
				$error("std_dev: expected %0d, actual %0d", st.std_dev, beat[30:16]);
				mismatches++;
			end
			if (beat[31 +: CNT_W] !== st.sample_count) begin
				$error("sample_count: expected %0d, actual %0d", st.sample_count,
					beat[31 +: CNT_W]);
				mismatches++;
			end
			if ((beat >> RES_W) !== '0) begin
				$error("padding: expected %0d, actual %0d", 0, beat >> RES_W);
				mismatches++;
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [15:0]       s_tdata;
	logic              s_tlast;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [DATA_W-1:0] m_tdata;

	stats_scoreboard sb;
	int  send_idle_pct;
	int  recv_stall_pct;
	bit  hold_req;
	bit  hold_seen = 1'b0;
	int  hold_left = 0;
	int  quiet_cycles = 0;
	int  phase_items;

	int dir_smp[22] = '{32767, -32768, -32768, 32767, -32768, -32768, -32767,
		-1, 0, 0, 32767, -32768, 32767, -32768, 1, 2, 0, -1, -1, 100, 100, 100};
	bit dir_end[22] = '{1, 1, 0, 1, 0, 0, 1, 0, 0, 1, 0, 0, 0, 1, 0, 1,
		0, 0, 1, 0, 0, 1};

	stream_mean_and_std_dev #(
		.MAX_SET_SIZE(MAX_SET)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (hold_req && !hold_seen) begin
			hold_seen = 1'b1;
			hold_left = HOLD_LEN;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_MAX) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic send_sample(input logic [15:0] smp, input logic lst);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= smp;
		s_tlast <= lst;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_sample(smp, lst);
		phase_items++;
	endtask

	function automatic logic [15:0] pick_sample(int flavour, logic [15:0] base);
		logic [15:0] corners[4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
		case (flavour)
			0: return 16'($urandom);
			1: return corners[2'($urandom_range(3))];
			2: return base + 16'($urandom_range(15)) - 16'd8;
			default: return 16'($urandom_range(127)) - 16'd64;
		endcase
	endfunction

	task automatic send_random_set();
		int          len;
		int          flavour;
		logic [15:0] base;
		len = ($urandom_range(9) == 0) ? $urandom_range(9, 300) : $urandom_range(1, 8);
		flavour = $urandom_range(3);
		base = 16'($urandom);
		for (int i = 0; i < len; i++)
			send_sample(pick_sample(flavour, base), i == len - 1);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.expected_stats.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_smp[i])
			send_sample(dir_smp[i][15:0], dir_end[i]);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  hold_req = 1'b1; end
				1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
				default: begin send_idle_pct = 20; recv_stall_pct = 20; end
			endcase
			phase_items = 0;
			while (phase_items < PHASE_ITEMS)
				send_random_set();
			drain();
		end

		repeat (LATENCY + 10) @(posedge clk);
		if (sb.expected_stats.size() != 0)
			$error("%0d results never arrived", sb.expected_stats.size());
		if (sb.mismatches == 0 && sb.expected_stats.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
